FILE: design/mwm_pkg.sv
`timescale 1ns / 1ps
package mwm_pkg;

   // command, wheel and queue geometry
   localparam int CMD_W         = 16;
   localparam int DB_W          = 15;
   localparam int WHEEL_W       = 19;
   localparam int QUOT_W        = 16;
   localparam int QUEUE_DEPTH   = 4;
   localparam int FRAC_BITS_DEF = 15;
   localparam int ANGLE_BITS_DEF = 16;
   localparam int TRIG_BITS_DEF = 10;

   // configuration register indexes
   localparam logic [1:0] REG_FIELD_ORIENTED  = 2'd0;
   localparam logic [1:0] REG_INPUT_DEADBAND  = 2'd1;
   localparam logic [1:0] REG_OUTPUT_DEADBAND = 2'd2;

   localparam logic [14:0] IN_DB_RESET  = 15'd6554;
   localparam logic [14:0] OUT_DB_RESET = 15'd9830;

   // full scale of a wheel command, 1.0 in Q1.15
   localparam logic [WHEEL_W-1:0] WHEEL_ONE = WHEEL_W'(32768);

   // sine series coefficients, Q30
   localparam longint Q30_ONE = 64'sd1 << 30;
   localparam longint C1 = 64'sd1686629713;
   localparam longint C3 = -64'sd693598670;
   localparam longint C5 = 64'sd85569270;
   localparam longint C7 = -64'sd5026990;
   localparam longint C9 = 64'sd172270;

   typedef struct packed {
      logic signed [WHEEL_W-1:0] fl;
      logic signed [WHEEL_W-1:0] fr;
      logic signed [WHEEL_W-1:0] bl;
      logic signed [WHEEL_W-1:0] br;
   } wheel_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_MAX,
      B_DIV,
      B_DONE
   } back_state_type;

   // quarter wave sine entry, evaluated at elaboration only
   function automatic longint quarter_sine(input int k, input int qbits, input int frac);
      longint t;
      longint t2;
      longint p;
      t  = longint'(k) << (30 - qbits);
      t2 = (t * t) / Q30_ONE;
      p  = C9;
      p  = C7 + (t2 * p) / Q30_ONE;
      p  = C5 + (t2 * p) / Q30_ONE;
      p  = C3 + (t2 * p) / Q30_ONE;
      p  = C1 + (t2 * p) / Q30_ONE;
      p  = (t * p) / Q30_ONE;
      if (p < 0) begin
         p = 0;
      end
      if (p > Q30_ONE) begin
         p = Q30_ONE;
      end
      if (frac < 30) begin
         p = (p + (64'sd1 << (29 - frac))) >>> (30 - frac);
      end
      return p;
   endfunction

   // magnitude below threshold forces zero
   function automatic logic signed [CMD_W-1:0] deadband_cmd(
      input logic signed [CMD_W-1:0] v, input logic [DB_W-1:0] thr);
      logic [CMD_W:0] mag;
      mag = v[CMD_W-1] ? (CMD_W+1)'(-$signed({v[CMD_W-1], v})) : {1'b0, v};
      return (mag < (CMD_W+1)'(thr)) ? '0 : v;
   endfunction

   // clamp to signed 16 bits
   function automatic logic [CMD_W-1:0] sat_cmd(input logic signed [WHEEL_W:0] v);
      logic [CMD_W-1:0] r;
      if (v > (WHEEL_W+1)'(32767)) begin
         r = 16'h7FFF;
      end else if (v < -(WHEEL_W+1)'(32768)) begin
         r = 16'h8000;
      end else begin
         r = v[CMD_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: design/mwm_front.sv
`timescale 1ns / 1ps
module mwm_front #(
   parameter int FRAC_BITS       = mwm_pkg::FRAC_BITS_DEF,
   parameter int ANGLE_BITS      = mwm_pkg::ANGLE_BITS_DEF,
   parameter int TRIG_TABLE_BITS = mwm_pkg::TRIG_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [63:0]             in_data,
   input  logic                    field_oriented,
   input  logic [14:0]             input_deadband,
   output logic                    push_valid,
   input  logic                    push_ready,
   output mwm_pkg::wheel_type      push_data
);
   import mwm_pkg::*;

   localparam int TB    = TRIG_TABLE_BITS;
   localparam int QBITS = TB - 2;
   localparam int QN    = 1 << QBITS;
   localparam int SW    = FRAC_BITS + 2;
   localparam int PW    = CMD_W + SW;

   logic                    pipe_move;
   logic                    accept;
   logic [TB-1:0]           idx_s;
   logic [TB-1:0]           idx_c;
   logic [QBITS:0]          ks_in, kc_in;

   logic                    v1_ff, v2_ff, v3_ff;
   logic signed [CMD_W-1:0] x1_ff, y1_ff, r1_ff;
   logic                    fo1_ff;
   logic [QBITS:0]          ks1_ff, kc1_ff;
   logic                    ns1_ff, nc1_ff;

   logic signed [CMD_W-1:0] x2_ff, y2_ff, r2_ff;
   logic                    fo2_ff;
   logic signed [SW-1:0]    s2_ff, c2_ff;

   logic signed [CMD_W-1:0] x3_ff, y3_ff, r3_ff;
   logic                    fo3_ff;
   logic signed [PW-1:0]    xc3_ff, ys3_ff, yc3_ff, xs3_ff;

   logic [FRAC_BITS:0]      qsin_rom [QN+1];
   logic signed [SW-1:0]    s_rom, c_rom;
   logic signed [PW:0]      sum_x, sum_y, rnd_x, rnd_y;
   logic signed [WHEEL_W-1:0] xr, yr, rr;

   // quarter wave sine table
   for (genvar g = 0; g <= QN; g++) begin : g_rom
      assign qsin_rom[g] = (FRAC_BITS+1)'(quarter_sine(g, QBITS, FRAC_BITS));
   end

   // whole pipe advances unless the last stage cannot push
   assign pipe_move = !v3_ff || push_ready;
   assign in_ready  = pipe_move;
   assign accept    = in_valid && pipe_move;

   // table index from the heading
   if (ANGLE_BITS >= TB) begin : g_idx_shr
      assign idx_s = in_data[48+ANGLE_BITS-1 -: TB];
   end else begin : g_idx_shl
      assign idx_s = {in_data[48 +: ANGLE_BITS], (TB-ANGLE_BITS)'(0)};
   end
   assign idx_c = idx_s + TB'(QN);

   // fold to the first quadrant
   assign ks_in = idx_s[TB-2] ? (QBITS+1)'(QN) - {1'b0, idx_s[QBITS-1:0]}
                              : {1'b0, idx_s[QBITS-1:0]};
   assign kc_in = idx_c[TB-2] ? (QBITS+1)'(QN) - {1'b0, idx_c[QBITS-1:0]}
                              : {1'b0, idx_c[QBITS-1:0]};

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (pipe_move) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // stage one: deadband and table address
   always_ff @(posedge clock) begin
      if (accept) begin
         x1_ff  <= deadband_cmd(in_data[15:0], input_deadband);
         y1_ff  <= deadband_cmd(in_data[31:16], input_deadband);
         r1_ff  <= deadband_cmd(in_data[47:32], input_deadband);
         fo1_ff <= field_oriented;
         ks1_ff <= ks_in;
         kc1_ff <= kc_in;
         ns1_ff <= idx_s[TB-1];
         nc1_ff <= idx_c[TB-1];
      end
   end

   // stage two: table read with quadrant sign
   assign s_rom = ns1_ff ? -SW'(qsin_rom[ks1_ff]) : SW'(qsin_rom[ks1_ff]);
   assign c_rom = nc1_ff ? -SW'(qsin_rom[kc1_ff]) : SW'(qsin_rom[kc1_ff]);

   always_ff @(posedge clock) begin
      if (pipe_move) begin
         x2_ff  <= x1_ff;
         y2_ff  <= y1_ff;
         r2_ff  <= r1_ff;
         fo2_ff <= fo1_ff;
         s2_ff  <= s_rom;
         c2_ff  <= c_rom;
      end
   end

   // stage three: rotation products
   always_ff @(posedge clock) begin
      if (pipe_move) begin
         x3_ff  <= x2_ff;
         y3_ff  <= y2_ff;
         r3_ff  <= r2_ff;
         fo3_ff <= fo2_ff;
         xc3_ff <= PW'(x2_ff) * PW'(c2_ff);
         ys3_ff <= PW'(y2_ff) * PW'(s2_ff);
         yc3_ff <= PW'(y2_ff) * PW'(c2_ff);
         xs3_ff <= PW'(x2_ff) * PW'(s2_ff);
      end
   end

   // rounding half up, then the wheel mix
   assign sum_x = (PW+1)'(xc3_ff) + (PW+1)'(ys3_ff);
   assign sum_y = (PW+1)'(yc3_ff) - (PW+1)'(xs3_ff);
   assign rnd_x = (sum_x + ((PW+1)'(1) <<< (FRAC_BITS-1))) >>> FRAC_BITS;
   assign rnd_y = (sum_y + ((PW+1)'(1) <<< (FRAC_BITS-1))) >>> FRAC_BITS;
   assign xr = fo3_ff ? rnd_x[WHEEL_W-1:0] : WHEEL_W'(x3_ff);
   assign yr = fo3_ff ? rnd_y[WHEEL_W-1:0] : WHEEL_W'(y3_ff);
   assign rr = WHEEL_W'(r3_ff);

   assign push_valid   = v3_ff;
   assign push_data.fl = xr + yr + rr;
   assign push_data.fr = yr - xr - rr;
   assign push_data.bl = yr - xr + rr;
   assign push_data.br = xr + yr - rr;

endmodule

FILE: design/mwm_queue.sv
`timescale 1ns / 1ps
module mwm_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  mwm_pkg::wheel_type  push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output mwm_pkg::wheel_type  pop_data
);
   import mwm_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);

   wheel_type       store_ff [QUEUE_DEPTH];
   logic [AW-1:0]   wr_ff, rd_ff;
   logic [AW:0]     count_ff;
   logic            do_push, do_pop;

   assign push_ready = count_ff != (AW+1)'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = store_ff[rd_ff];

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ff] <= push_data;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= wr_ff + AW'(1);
         end
         if (do_pop) begin
            rd_ff <= rd_ff + AW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + (AW+1)'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - (AW+1)'(1);
         end
      end
   end

endmodule

FILE: design/mwm_back.sv
`timescale 1ns / 1ps
module mwm_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  mwm_pkg::wheel_type  pop_data,
   input  logic [14:0]         output_deadband,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [63:0]         out_data,
   output logic                out_scaled
);
   import mwm_pkg::*;

   localparam int RW = WHEEL_W + 1;
   localparam int CW = $clog2(QUOT_W);

   back_state_type            state_ff, state_in;
   logic signed [WHEEL_W-1:0] w_ff   [4];
   logic [WHEEL_W-1:0]        mag_ff [4];
   logic [RW-1:0]             rem_ff [4];
   logic [QUOT_W-1:0]         lo_ff  [4];
   logic [QUOT_W-1:0]         q_ff   [4];
   logic [WHEEL_W-1:0]        mx_ff;
   logic                      scaled_ff;
   logic [CW-1:0]             cnt_ff;
   logic                      out_valid_ff;
   logic [63:0]               out_data_ff;
   logic                      out_scaled_ff;

   logic signed [WHEEL_W-1:0] w_new [4];
   logic [WHEEL_W-1:0]        mx01, mx23, mx_all;
   logic [RW-1:0]             trial [4];
   logic                      fits  [4];
   logic signed [WHEEL_W:0]   fin   [4];
   logic [15:0]               drive [4];
   logic                      load_out;

   assign w_new[0] = pop_data.fl;
   assign w_new[1] = pop_data.fr;
   assign w_new[2] = pop_data.bl;
   assign w_new[3] = pop_data.br;

   // largest magnitude
   assign mx01   = (mag_ff[0] > mag_ff[1]) ? mag_ff[0] : mag_ff[1];
   assign mx23   = (mag_ff[2] > mag_ff[3]) ? mag_ff[2] : mag_ff[3];
   assign mx_all = (mx01 > mx23) ? mx01 : mx23;

   // one restoring step per lane, and the final value with deadband
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         trial[i] = {rem_ff[i][RW-2:0], lo_ff[i][QUOT_W-1]};
         fits[i]  = trial[i] >= RW'(mx_ff);
         if (scaled_ff) begin
            fin[i] = w_ff[i][WHEEL_W-1] ? -(WHEEL_W+1)'(q_ff[i]) : (WHEEL_W+1)'(q_ff[i]);
            if (q_ff[i] < QUOT_W'(output_deadband)) begin
               fin[i] = '0;
            end
         end else begin
            fin[i] = (WHEEL_W+1)'(w_ff[i]);
            if (mag_ff[i] < WHEEL_W'(output_deadband)) begin
               fin[i] = '0;
            end
         end
      end
      drive[0] = sat_cmd(-fin[0]);
      drive[1] = sat_cmd(fin[1]);
      drive[2] = sat_cmd(-fin[2]);
      drive[3] = sat_cmd(fin[3]);
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      pop_ready = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         B_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               state_in = B_MAX;
            end
         end
         B_MAX: begin
            state_in = (mx_all > WHEEL_ONE) ? B_DIV : B_DONE;
         end
         B_DIV: begin
            if (cnt_ff == CW'(QUOT_W-1)) begin
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (!out_valid_ff || out_ready) begin
               load_out = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath of the divider lanes
   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            for (int i = 0; i < 4; i++) begin
               w_ff[i]   <= w_new[i];
               mag_ff[i] <= w_new[i][WHEEL_W-1] ? -w_new[i] : w_new[i];
            end
         end
         B_MAX: begin
            mx_ff     <= mx_all;
            scaled_ff <= mx_all > WHEEL_ONE;
            cnt_ff    <= '0;
            for (int i = 0; i < 4; i++) begin
               rem_ff[i] <= RW'(mag_ff[i] >> 1);
               lo_ff[i]  <= {mag_ff[i][0], (QUOT_W-1)'(0)};
               q_ff[i]   <= '0;
            end
         end
         B_DIV: begin
            cnt_ff <= cnt_ff + CW'(1);
            for (int i = 0; i < 4; i++) begin
               rem_ff[i] <= fits[i] ? trial[i] - RW'(mx_ff) : trial[i];
               lo_ff[i]  <= lo_ff[i] << 1;
               q_ff[i]   <= {q_ff[i][QUOT_W-2:0], fits[i]};
            end
         end
         default: begin
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load_out) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_data_ff   <= {drive[3], drive[2], drive[1], drive[0]};
         out_scaled_ff <= scaled_ff;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_data   = out_data_ff;
   assign out_scaled = out_scaled_ff;

endmodule

FILE: design/mecanum_wheel_mixer.sv
`timescale 1ns / 1ps
// the back end takes a new transaction only once the last is loaded into its output
// register; when the wheels are rescaled, its 16-step restoring divider runs first
// the front end takes one transaction a cycle into a 4-entry queue, stalling while
// the queue is full and its last stage holds a result
// reset: synchronous, clears all handshakes and loads the register defaults
module mecanum_wheel_mixer #(
   parameter int FRAC_BITS       = mwm_pkg::FRAC_BITS_DEF,
   parameter int ANGLE_BITS      = mwm_pkg::ANGLE_BITS_DEF,
   parameter int TRIG_TABLE_BITS = mwm_pkg::TRIG_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // strafe_cmd, forward_cmd, twist_cmd, heading
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // front_left, front_right, back_left, back_right drive
   output logic [0:0]  rsp_tuser,   // was_scaled
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import mwm_pkg::*;

   logic        fo_ff;
   logic [14:0] ibd_ff;
   logic [14:0] obd_ff;
   logic        push_valid, push_ready, pop_valid, pop_ready;
   wheel_type   push_data, pop_data;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fo_ff  <= 1'b0;
         ibd_ff <= IN_DB_RESET;
         obd_ff <= OUT_DB_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_FIELD_ORIENTED:  fo_ff  <= csr_data[0];
            REG_INPUT_DEADBAND:  ibd_ff <= csr_data[14:0];
            REG_OUTPUT_DEADBAND: obd_ff <= csr_data[14:0];
            default: begin
            end
         endcase
      end
   end

   mwm_front #(
      .FRAC_BITS       (FRAC_BITS),
      .ANGLE_BITS      (ANGLE_BITS),
      .TRIG_TABLE_BITS (TRIG_TABLE_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .in_data        (req_tdata),
      .field_oriented (fo_ff),
      .input_deadband (ibd_ff),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_data      (push_data)
   );

   mwm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   mwm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_data        (pop_data),
      .output_deadband (obd_ff),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .out_data        (rsp_tdata),
      .out_scaled      (rsp_tuser[0])
   );

endmodule

FILE: bench/mecanum_wheel_mixer_tb.sv
`timescale 1ns / 1ps
module mecanum_wheel_mixer_tb;
   import mwm_pkg::*;

   typedef struct {
      logic [15:0] fl;
      logic [15:0] fr;
      logic [15:0] bl;
      logic [15:0] br;
      logic        scaled;
   } drive_set_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;

   // shadow of the block's registers
   logic        fo_mode;
   logic [14:0] in_db;
   logic [14:0] out_db;

   longint        sine_rom [0:1023];
   drive_set_type drive_queue [$];
   int            error_count;
   int            hold_off;
   logic          done_flag;

   mecanum_wheel_mixer DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // quarter wave series, Q30 products truncated toward zero
   function automatic longint wave_point(int k);
      longint t, t2, p;
      t  = longint'(k) <<< 22;
      t2 = (t * t) / (64'sd1 <<< 30);
      p  = 64'sd172270;
      p  = -64'sd5026990 + (t2 * p) / (64'sd1 <<< 30);
      p  = 64'sd85569270 + (t2 * p) / (64'sd1 <<< 30);
      p  = -64'sd693598670 + (t2 * p) / (64'sd1 <<< 30);
      p  = 64'sd1686629713 + (t2 * p) / (64'sd1 <<< 30);
      p  = (t * p) / (64'sd1 <<< 30);
      if (p < 0) p = 0;
      if (p > (64'sd1 <<< 30)) p = 64'sd1 <<< 30;
      return (p + (64'sd1 <<< 14)) >>> 15;
   endfunction

   initial begin
      longint v;
      for (int i = 0; i < 1024; i++) begin
         v = ((i >> 8) & 1) ? wave_point(256 - (i & 255)) : wave_point(i & 255);
         sine_rom[i] = ((i >> 9) & 1) ? -v : v;
      end
   end

   function automatic longint dead_zone(longint v, longint thr);
      longint m;
      m = (v < 0) ? -v : v;
      return (m < thr) ? 0 : v;
   endfunction

   function automatic logic [15:0] clamp16(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   function automatic drive_set_type mix_wheels(logic [63:0] cmd);
      drive_set_type d;
      longint x, y, r, s, c, nx, ny, mx, m;
      longint w [4];
      int idx;
      x = dead_zone(longint'($signed(cmd[15:0])), in_db);
      y = dead_zone(longint'($signed(cmd[31:16])), in_db);
      r = dead_zone(longint'($signed(cmd[47:32])), in_db);
      if (fo_mode) begin
         idx = int'(cmd[63:54]);
         s   = sine_rom[idx];
         c   = sine_rom[(idx + 256) & 1023];
         nx  = (x * c + y * s + 16384) >>> 15;
         ny  = (y * c - x * s + 16384) >>> 15;
         x   = nx;
         y   = ny;
      end
      w[0] = x + y + r;
      w[1] = -x + y - r;
      w[2] = -x + y + r;
      w[3] = x + y - r;
      mx = 0;
      for (int i = 0; i < 4; i++) begin
         m = (w[i] < 0) ? -w[i] : w[i];
         if (m > mx) mx = m;
      end
      d.scaled = (mx > 32768);
      for (int i = 0; i < 4; i++) begin
         if (d.scaled) w[i] = (w[i] * 32768) / mx;
         w[i] = dead_zone(w[i], out_db);
      end
      d.fl = clamp16(-w[0]);
      d.fr = clamp16(w[1]);
      d.bl = clamp16(-w[2]);
      d.br = clamp16(w[3]);
      return d;
   endfunction

   task automatic report_error(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   task automatic idle_cycles(int n);
      repeat (n) @(negedge clock);
   endtask

   // send one command transaction and record its expected wheels
   task automatic send_command(logic [15:0] sx, logic [15:0] fy, logic [15:0] tw,
                               logic [15:0] hd, bit gaps);
      int gap;
      gap = gaps ? int'($urandom_range(0, 17)) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         idle_cycles(gap);
      end
      req_tdata  <= {hd, tw, fy, sx};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      drive_queue.push_back(mix_wheels({hd, tw, fy, sx}));
      @(negedge clock);
   endtask

   task automatic write_register(logic [1:0] idx, logic [15:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_FIELD_ORIENTED:  fo_mode = val[0];
         REG_INPUT_DEADBAND:  in_db   = val[14:0];
         REG_OUTPUT_DEADBAND: out_db  = val[14:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      idle_cycles(1);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (drive_queue.size() != 0) @(negedge clock);
      idle_cycles(30);
   endtask

   // receiver: random stalls plus an optional long hold-off
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            rsp_tready <= 1'b0;
            hold_off--;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = int'($urandom_range(0, 16));
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // response checker
   initial begin
      drive_set_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (drive_queue.size() == 0) begin
               report_error("unexpected", rsp_tdata[15:0], 16'h0);
            end else begin
               want = drive_queue.pop_front();
               if (rsp_tdata[15:0] !== want.fl) report_error("fl", rsp_tdata[15:0], want.fl);
               if (rsp_tdata[31:16] !== want.fr)
                  report_error("fr", rsp_tdata[31:16], want.fr);
               if (rsp_tdata[47:32] !== want.bl)
                  report_error("bl", rsp_tdata[47:32], want.bl);
               if (rsp_tdata[63:48] !== want.br)
                  report_error("br", rsp_tdata[63:48], want.br);
               if (rsp_tuser[0] !== want.scaled)
                  report_error("scaled", {15'd0, rsp_tuser[0]}, {15'd0, want.scaled});
            end
         end
      end
   end

   function automatic logic [15:0] rand_cmd();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(0, 12000)) ^ ($urandom_range(0, 1) ? 16'hFFFF : 16'h0);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic test_directed();
      logic [15:0] edge_vals [6];
      edge_vals = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'd6554, 16'hE666};
      foreach (edge_vals[i]) send_command(edge_vals[i], 16'h0, 16'h0, 16'h0, 1'b0);
      send_command(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0, 1'b0);
      send_command(16'h8000, 16'h8000, 16'h8000, 16'h0, 1'b0);
      send_command(16'h8000, 16'h7FFF, 16'h8000, 16'h0, 1'b0);
      send_command(16'h4000, 16'h4000, 16'h0, 16'h0, 1'b0);
      send_command(16'h3000, 16'h3000, 16'h0, 16'h0, 1'b0);
      wait_drained();
      write_register(REG_FIELD_ORIENTED, 16'hFFFF);
      foreach (edge_vals[i]) send_command(16'h7FFF, 16'h4000, 16'h0, edge_vals[i], 1'b0);
      send_command(16'h7FFF, 16'h8000, 16'h2000, 16'h4000, 1'b0);
      send_command(16'h8000, 16'h7FFF, 16'h0, 16'hC000, 1'b0);
      send_command(16'h6000, 16'h6000, 16'h6000, 16'h2000, 1'b0);
      wait_drained();
   endtask

   task automatic test_random(int n, bit gaps);
      repeat (n) send_command(rand_cmd(), rand_cmd(), rand_cmd(), 16'($urandom), gaps);
      wait_drained();
   endtask

   task automatic test_back_pressure();
      hold_off = 200;
      repeat (12) send_command(rand_cmd(), rand_cmd(), rand_cmd(), 16'($urandom), 1'b0);
      wait_drained();
   endtask

   task automatic test_settings();
      write_register(REG_INPUT_DEADBAND, 16'h0000);
      write_register(REG_OUTPUT_DEADBAND, 16'h0000);
      test_random(200, 1'b1);
      write_register(REG_FIELD_ORIENTED, 16'h0000);
      write_register(REG_INPUT_DEADBAND, 16'hFFFF);
      write_register(REG_OUTPUT_DEADBAND, 16'h7FFF);
      test_random(150, 1'b1);
      write_register(REG_FIELD_ORIENTED, 16'h0001);
      write_register(REG_INPUT_DEADBAND, 16'($urandom_range(0, 32767)));
      write_register(REG_OUTPUT_DEADBAND, 16'($urandom_range(0, 32767)));
      write_register(2'd3, 16'h1234);
      test_random(200, 1'b0);
      write_register(REG_FIELD_ORIENTED, 16'h0000);
      write_register(REG_INPUT_DEADBAND, 16'd6554);
      write_register(REG_OUTPUT_DEADBAND, 16'd9830);
      test_random(200, 1'b1);
   endtask

   initial begin
      error_count = 0;
      hold_off    = 0;
      done_flag   = 1'b0;
      fo_mode     = 1'b0;
      in_db       = IN_DB_RESET;
      out_db      = OUT_DB_RESET;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      idle_cycles(2);
      test_directed();
      test_random(200, 1'b1);
      test_back_pressure();
      test_settings();
      done_flag = 1'b1;
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // run limit
   initial begin
      #3000000;
      if (!done_flag) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

endmodule
